/* rtl/vbis_pkg.sv */
// Shared types and constants for the vertical-blank interval statistics block.
`default_nettype none
package vbis_pkg;

   localparam int DISP_W = 2;
   localparam int SEQ_W  = 64;
   localparam int TIME_W = 63;
   localparam int CSR_W  = 3;
   localparam int CFG_W  = 8;
   localparam int MASK_W = 4;
   localparam int NUM_REFRESH = 4;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_REFRESH_A   = 3'd0;
   localparam logic [CSR_W-1:0] CSR_REFRESH_B   = 3'd1;
   localparam logic [CSR_W-1:0] CSR_REFRESH_C   = 3'd2;
   localparam logic [CSR_W-1:0] CSR_REFRESH_D   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_ACTIVE_MASK = 3'd4;

   localparam logic [CFG_W-1:0]  REFRESH_RESET = 8'd60;
   localparam logic [MASK_W-1:0] ACTIVE_RESET  = 4'hf;

   typedef enum logic {
      CMD_START,
      CMD_STORE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [DISP_W-1:0]       display;
      logic [SEQ_W-1:0]        seq;
      logic [TIME_W-1:0]       vtime;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV,
      B_RD,
      B_ACC,
      B_UPD,
      B_DONE
   } back_state_type;

endpackage
`default_nettype wire

/* rtl/vbis_front.sv */
// Front end: accepts events, drops inactive displays, marks first events as start points.
`default_nettype none
module vbis_front import vbis_pkg::*; #(
   parameter int NUM_DISPLAYS = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [DISP_W-1:0]  req_display,
   input  wire logic [SEQ_W-1:0]   req_vblank_seq,
   input  wire logic [TIME_W-1:0]  req_vblank_time,
   input  wire logic [MASK_W-1:0]  active_mask,
   output logic                    push,
   output cmd_type                 push_cmd,
   input  wire logic               q_full
);
   localparam int DW = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;

   logic                   stage_valid_ff, stage_valid_in;
   logic [DISP_W-1:0]      stage_disp_ff;
   logic [SEQ_W-1:0]       stage_seq_ff;
   logic [TIME_W-1:0]      stage_time_ff;
   logic [NUM_DISPLAYS-1:0] started_ff, started_in;
   logic                   present, active, need_push, consume;
   logic [DW-1:0]          dix;

   always_comb begin
      dix       = DW'(stage_disp_ff);
      present   = 32'(stage_disp_ff) < NUM_DISPLAYS;
      active    = present && active_mask[stage_disp_ff];
      need_push = stage_valid_ff && active;
      consume   = stage_valid_ff && !(need_push && q_full);
      req_stall = stage_valid_ff && need_push && q_full;
      push      = need_push && !q_full;
      push_cmd.kind    = (present && started_ff[dix]) ? CMD_STORE : CMD_START;
      push_cmd.display = stage_disp_ff;
      push_cmd.seq     = stage_seq_ff;
      push_cmd.vtime   = stage_time_ff;
      started_in = started_ff;
      if (push) begin
         started_in[dix] = 1'b1;
      end
      stage_valid_in = (stage_valid_ff && !consume) || (req_valid && !req_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         started_ff     <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         started_ff     <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_disp_ff <= req_display;
         stage_seq_ff  <= req_vblank_seq;
         stage_time_ff <= req_vblank_time;
      end
   end

endmodule
`default_nettype wire

/* rtl/vbis_queue.sv */
// Two-entry command queue between front end and evaluator.
`default_nettype none
module vbis_queue import vbis_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         q_valid,
   output cmd_type      q_cmd,
   input  wire logic    pop
);
   cmd_type    slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;

   assign full    = cnt_ff == 2'd2;
   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd   = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (pop) begin
            rptr_ff <= !rptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

/* rtl/vbis_back.sv */
// Evaluator: stores frames per display and walks a full window to build the report.
`default_nettype none
module vbis_back import vbis_pkg::*; #(
   parameter int NUM_DISPLAYS = 4,
   parameter int MAX_FRAMES   = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire cmd_type                           q_cmd,
   output logic                                   pop,
   input  wire logic [NUM_REFRESH-1:0][CFG_W-1:0] refresh,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [DISP_W-1:0]                      rsp_report_display,
   output logic [7:0]                             rsp_frames,
   output logic signed [63:0]                     rsp_total_time,
   output logic signed [63:0]                     rsp_mean_interval,
   output logic signed [63:0]                     rsp_low_dev,
   output logic [62:0]                            rsp_high_dev,
   output logic [7:0]                             rsp_backwards_count,
   output logic [7:0]                             rsp_late_count,
   output logic [31:0]                            rsp_min_late_gap,
   output logic [31:0]                            rsp_max_late_gap
);
   localparam int DW    = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;
   localparam int DEPTH = NUM_DISPLAYS * MAX_FRAMES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int WW    = (CNT_W > 8) ? CNT_W : 8;

   back_state_type state_ff, state_in;

   logic [TIME_W-1:0] mem_t [DEPTH];
   logic [SEQ_W-1:0]  mem_s [DEPTH];
   logic [TIME_W-1:0] rd_t_ff;
   logic [SEQ_W-1:0]  rd_s_ff;

   logic [CNT_W-1:0]  count_ff   [NUM_DISPLAYS];
   logic [TIME_W-1:0] start_t_ff [NUM_DISPLAYS];
   logic [SEQ_W-1:0]  start_s_ff [NUM_DISPLAYS];

   logic [DISP_W-1:0]  cur_d_ff;
   logic [WW-1:0]      n_ff, i_ff;
   logic signed [63:0] total_ff, avg_ff, delta_ff, lo_ff, hi_ff;
   logic [63:0]        quo_ff, gap_ff;
   logic [WW:0]        rem_ff;
   logic               neg_ff;
   logic [5:0]         step_ff;
   logic [TIME_W-1:0]  prev_t_ff;
   logic [SEQ_W-1:0]   prev_s_ff;
   logic [7:0]         nback_ff, nlate_ff;
   logic [31:0]        lo_gap_ff, hi_gap_ff;

   logic [DW-1:0]      qdix, cdix;
   logic [CNT_W-1:0]   cnt_new;
   logic [WW-1:0]      win;
   logic               eval_go, out_free;
   logic signed [63:0] total_new;
   logic [WW:0]        rem_sh, rem_next;
   logic [63:0]        quo_next;
   logic [AW-1:0]      waddr, raddr;
   logic signed [64:0] dev_wide;
   logic signed [63:0] dev;
   logic               late;
   logic [31:0]        g;

   always_comb begin
      qdix    = DW'(q_cmd.display);
      cdix    = DW'(cur_d_ff);
      cnt_new = count_ff[qdix] + CNT_W'(1);
      win     = WW'(refresh[q_cmd.display]);
      if (win == '0) begin
         win = WW'(1);
      end
      if (win > WW'(MAX_FRAMES)) begin
         win = WW'(MAX_FRAMES);
      end
      eval_go   = q_cmd.kind == CMD_STORE && WW'(cnt_new) >= win;
      total_new = $signed({1'b0, q_cmd.vtime}) - $signed({1'b0, start_t_ff[qdix]});
      waddr = AW'(32'(qdix) * MAX_FRAMES) + AW'(count_ff[qdix]);
      raddr = AW'(32'(cdix) * MAX_FRAMES) + AW'(i_ff);
      // one restoring-division step
      rem_sh = {rem_ff[WW-1:0], quo_ff[63]};
      if (rem_sh >= {1'b0, n_ff}) begin
         rem_next = rem_sh - {1'b0, n_ff};
         quo_next = {quo_ff[62:0], 1'b1};
      end else begin
         rem_next = rem_sh;
         quo_next = {quo_ff[62:0], 1'b0};
      end
      // saturate mean minus interval
      dev_wide = {avg_ff[63], avg_ff} - {delta_ff[63], delta_ff};
      if (dev_wide[64] != dev_wide[63]) begin
         dev = dev_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         dev = dev_wide[63:0];
      end
      late = gap_ff >= 64'd2 && !gap_ff[63];
      g    = (|gap_ff[63:32]) ? 32'hffff_ffff : gap_ff[31:0];
      out_free = !rsp_valid || !rsp_stall;
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               if (eval_go) begin
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            if (step_ff == 6'd63) begin
               state_in = B_RD;
            end
         end
         B_RD:  state_in = B_ACC;
         B_ACC: state_in = B_UPD;
         B_UPD: begin
            state_in = (i_ff + WW'(1) == n_ff) ? B_DONE : B_RD;
         end
         B_DONE: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         rsp_valid <= 1'b0;
         for (int k = 0; k < NUM_DISPLAYS; k++) begin
            count_ff[k]   <= '0;
            start_t_ff[k] <= '0;
            start_s_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == B_IDLE && q_valid) begin
            if (q_cmd.kind == CMD_START) begin
               start_t_ff[qdix] <= q_cmd.vtime;
               start_s_ff[qdix] <= q_cmd.seq;
            end else if (!eval_go) begin
               count_ff[qdix] <= cnt_new;
            end
         end
         if (state_ff == B_DONE && out_free) begin
            rsp_valid        <= 1'b1;
            count_ff[cdix]   <= '0;
            start_t_ff[cdix] <= prev_t_ff;
            start_s_ff[cdix] <= prev_s_ff;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && q_valid && q_cmd.kind == CMD_STORE) begin
         mem_t[waddr] <= q_cmd.vtime;
         mem_s[waddr] <= q_cmd.seq;
      end
      if (state_ff == B_RD) begin
         rd_t_ff <= mem_t[raddr];
         rd_s_ff <= mem_s[raddr];
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            cur_d_ff <= q_cmd.display;
            n_ff     <= WW'(cnt_new);
            total_ff <= total_new;
            neg_ff   <= total_new[63];
            quo_ff   <= total_new[63] ? -total_new : total_new;
            rem_ff   <= '0;
            step_ff  <= '0;
         end
         B_DIV: begin
            rem_ff  <= rem_next;
            quo_ff  <= quo_next;
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               avg_ff    <= neg_ff ? -$signed(quo_next) : $signed(quo_next);
               i_ff      <= '0;
               prev_t_ff <= start_t_ff[cdix];
               prev_s_ff <= start_s_ff[cdix];
               lo_ff     <= '0;
               hi_ff     <= '0;
               nback_ff  <= '0;
               nlate_ff  <= '0;
               lo_gap_ff <= '0;
               hi_gap_ff <= '0;
            end
         end
         B_RD: begin
         end
         B_ACC: begin
            delta_ff  <= $signed({1'b0, rd_t_ff}) - $signed({1'b0, prev_t_ff});
            gap_ff    <= rd_s_ff - prev_s_ff;
            prev_t_ff <= rd_t_ff;
            prev_s_ff <= rd_s_ff;
         end
         B_UPD: begin
            i_ff <= i_ff + WW'(1);
            if (delta_ff[63]) begin
               nback_ff <= nback_ff + 8'd1;
            end
            if (dev < lo_ff) begin
               lo_ff <= dev;
            end
            if (dev > hi_ff) begin
               hi_ff <= dev;
            end
            if (late) begin
               if (nlate_ff == 8'd0 || g < lo_gap_ff) begin
                  lo_gap_ff <= g;
               end
               if (g > hi_gap_ff) begin
                  hi_gap_ff <= g;
               end
               nlate_ff <= nlate_ff + 8'd1;
            end
         end
         B_DONE: begin
            if (out_free) begin
               rsp_report_display  <= cur_d_ff;
               rsp_frames          <= n_ff[7:0];
               rsp_total_time      <= total_ff;
               rsp_mean_interval   <= avg_ff;
               rsp_low_dev         <= lo_ff;
               rsp_high_dev        <= hi_ff[62:0];
               rsp_backwards_count <= nback_ff;
               rsp_late_count      <= nlate_ff;
               rsp_min_late_gap    <= lo_gap_ff;
               rsp_max_late_gap    <= hi_gap_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/vblank_interval_stats.sv */
// Top level: configuration registers, front end, command queue and evaluator.
// Usage:
//   req_* carries one vertical-blank event (display, sequence, timestamp);
//   an item is taken when req_valid is high and req_stall is low.
//   rsp_* carries one statistics report per finished window, taken when
//   rsp_valid is high and rsp_stall is low.
//   csr_* writes a register (refresh counts A..D at indexes 0..3, active
//   mask at 4); csr_ready is always high. Write only while the block is idle.
// Flow:
//   Events that only start or extend a window pass through the front stage
//   and the two-entry queue; the evaluator takes them while it is idle.
//   The event that completes a window of n frames runs a one-bit-per-cycle
//   divider for the mean, then a walk over the frame memory in which each
//   frame passes through read, difference and min/max update states.
// Reset clears window counts, start points and started flags; the frame
// memory is not cleared. While rsp_stall holds, the report waits in the
// output register and the queue keeps taking events until it fills.
`default_nettype none
module vblank_interval_stats import vbis_pkg::*; #(
   parameter int NUM_DISPLAYS = 4,
   parameter int MAX_FRAMES   = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [DISP_W-1:0]  req_display,
   input  wire logic [SEQ_W-1:0]   req_vblank_seq,
   input  wire logic [TIME_W-1:0]  req_vblank_time,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [DISP_W-1:0]       rsp_report_display,
   output logic [7:0]              rsp_frames,
   output logic signed [63:0]      rsp_total_time,
   output logic signed [63:0]      rsp_mean_interval,
   output logic signed [63:0]      rsp_low_dev,
   output logic [62:0]             rsp_high_dev,
   output logic [7:0]              rsp_backwards_count,
   output logic [7:0]              rsp_late_count,
   output logic [31:0]             rsp_min_late_gap,
   output logic [31:0]             rsp_max_late_gap,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CSR_W-1:0]   csr_index,
   input  wire logic [CFG_W-1:0]   csr_wdata
);
   logic [NUM_REFRESH-1:0][CFG_W-1:0] refresh_ff;
   logic [MASK_W-1:0]                 active_ff;
   logic    push, q_full, q_valid, pop;
   cmd_type push_cmd, q_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_ff <= {NUM_REFRESH{REFRESH_RESET}};
         active_ff  <= ACTIVE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REFRESH_A:   refresh_ff[0] <= csr_wdata;
            CSR_REFRESH_B:   refresh_ff[1] <= csr_wdata;
            CSR_REFRESH_C:   refresh_ff[2] <= csr_wdata;
            CSR_REFRESH_D:   refresh_ff[3] <= csr_wdata;
            CSR_ACTIVE_MASK: active_ff     <= csr_wdata[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   vbis_front #(.NUM_DISPLAYS(NUM_DISPLAYS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_display, .req_vblank_seq,
      .req_vblank_time, .active_mask(active_ff), .push, .push_cmd, .q_full
   );

   vbis_queue u_queue (
      .clock, .reset, .push, .push_cmd, .full(q_full), .q_valid, .q_cmd, .pop
   );

   vbis_back #(.NUM_DISPLAYS(NUM_DISPLAYS), .MAX_FRAMES(MAX_FRAMES)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .pop, .refresh(refresh_ff),
      .rsp_valid, .rsp_stall, .rsp_report_display, .rsp_frames, .rsp_total_time,
      .rsp_mean_interval, .rsp_low_dev, .rsp_high_dev, .rsp_backwards_count,
      .rsp_late_count, .rsp_min_late_gap, .rsp_max_late_gap
   );

endmodule
`default_nettype wire

/* rtl/vbis_checker.sv */
// Port-level checks on reports, bound to the top level.
`default_nettype none
module vbis_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_frames,
   input wire logic [7:0]  rsp_backwards_count,
   input wire logic [7:0]  rsp_late_count,
   input wire logic [31:0] rsp_min_late_gap,
   input wire logic [31:0] rsp_max_late_gap
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("report dropped while stalled");

   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frames != 8'd0 && rsp_backwards_count <= rsp_frames
                    && rsp_late_count <= rsp_frames)
      else $error("report counts exceed frame count");

   a_gaps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_late_gap <= rsp_max_late_gap)
      else $error("late gap bounds out of order");

   a_nolate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_late_count == 8'd0 |->
         rsp_min_late_gap == 32'd0 && rsp_max_late_gap == 32'd0)
      else $error("late gaps set without late frames");
endmodule

bind vblank_interval_stats vbis_checker u_vbis_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_frames, .rsp_backwards_count,
   .rsp_late_count, .rsp_min_late_gap, .rsp_max_late_gap
);
`default_nettype wire

/* tb/tb_vblank_interval_stats.sv */
// Self-checking testbench for the vertical-blank interval statistics block.
`timescale 1ns / 1ps
`default_nettype none
module tb_vblank_interval_stats;
   import vbis_pkg::*;

   localparam int NDISP = 4;
   localparam int NFRM  = 128;
   localparam int LIMIT = 3000000;
   localparam logic [CSR_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic signed [64:0] DEV_MAX = 65'sh0_7fff_ffff_ffff_ffff;
   localparam logic signed [64:0] DEV_MIN = -DEV_MAX - 65'sd1;
   localparam logic [62:0] TIME_MAX = {63{1'b1}};
   localparam logic [63:0] FRAME_NS = 64'd16666667;

   typedef struct {
      logic [DISP_W-1:0] display;
      logic [SEQ_W-1:0]  seq;
      logic [TIME_W-1:0] vtime;
   } vblank_ev_type;

   typedef struct {
      logic [DISP_W-1:0]  display;
      logic [7:0]         frames;
      logic signed [63:0] total;
      logic signed [63:0] mean;
      logic signed [63:0] low_dev;
      logic [62:0]        high_dev;
      logic [7:0]         backwards;
      logic [7:0]         late;
      logic [31:0]        min_gap;
      logic [31:0]        max_gap;
   } window_stats_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [DISP_W-1:0] req_display;
   logic [SEQ_W-1:0] req_vblank_seq;
   logic [TIME_W-1:0] req_vblank_time;
   logic rsp_valid, rsp_stall;
   logic [DISP_W-1:0] rsp_report_display;
   logic [7:0] rsp_frames;
   logic signed [63:0] rsp_total_time, rsp_mean_interval, rsp_low_dev;
   logic [62:0] rsp_high_dev;
   logic [7:0] rsp_backwards_count, rsp_late_count;
   logic [31:0] rsp_min_late_gap, rsp_max_late_gap;
   logic csr_valid, csr_ready;
   logic [CSR_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   vblank_interval_stats dut (.*);

   // predictor state
   logic [7:0]  refresh [NDISP];
   logic [3:0]  active;
   logic [63:0] win_time [NDISP][NFRM];
   logic [63:0] win_seq [NDISP][NFRM];
   int          win_count [NDISP];
   logic [63:0] start_time [NDISP];
   logic [63:0] start_seq [NDISP];
   logic        started [NDISP];

   vblank_ev_type    pending_events[$];
   window_stats_type expected_stats[$];
   int  errors = 0;
   int  cycles = 0;
   bit  quiet = 0;
   bit  hold_req = 0;
   bit  hold_done = 0;
   bit  req_taken = 0;
   int  send_gap = 0;
   int  stall_cnt = 0;

   logic [63:0] trk_seq [NDISP];
   logic [62:0] trk_time [NDISP];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int window_len(int d);
      int n;
      n = int'(refresh[d]);
      if (n == 0) n = 1;
      if (n > NFRM) n = NFRM;
      return n;
   endfunction

   task automatic close_window(int d);
      window_stats_type s;
      logic [63:0] pt, ps, acc, gap;
      logic signed [63:0] delta, nn, lo, hi, dev;
      logic signed [64:0] wide;
      logic [31:0] g;
      int n, nback, nlate;
      n = win_count[d];
      pt = start_time[d];
      acc = 0;
      for (int i = 0; i < n; i++) begin
         acc += win_time[d][i] - pt;
         pt = win_time[d][i];
      end
      s.display = DISP_W'(d);
      s.frames = 8'(n);
      s.total = acc;
      nn = 64'(n);
      s.mean = s.total / nn;
      pt = start_time[d];
      ps = start_seq[d];
      lo = 0; hi = 0; nback = 0; nlate = 0;
      s.min_gap = 0; s.max_gap = 0;
      for (int i = 0; i < n; i++) begin
         delta = win_time[d][i] - pt;
         gap = win_seq[d][i] - ps;
         wide = {s.mean[63], s.mean} - {delta[63], delta};
         dev = (wide > DEV_MAX) ? DEV_MAX[63:0]
             : (wide < DEV_MIN) ? DEV_MIN[63:0] : wide[63:0];
         pt = win_time[d][i];
         ps = win_seq[d][i];
         if (delta < 0) nback++;
         if (dev < lo) lo = dev;
         if (dev > hi) hi = dev;
         if (gap >= 2 && !gap[63]) begin
            g = (gap > 64'hffff_ffff) ? 32'hffff_ffff : gap[31:0];
            if (nlate == 0 || g < s.min_gap) s.min_gap = g;
            if (g > s.max_gap) s.max_gap = g;
            nlate++;
         end
      end
      s.low_dev = lo;
      s.high_dev = hi[62:0];
      s.backwards = 8'(nback);
      s.late = 8'(nlate);
      expected_stats.push_back(s);
      win_count[d] = 0;
      start_time[d] = pt;
      start_seq[d] = ps;
   endtask

   task automatic track_vblank(vblank_ev_type ev);
      int d;
      d = int'(ev.display);
      if (!active[d]) return;
      if (!started[d]) begin
         started[d] = 1;
         start_time[d] = {1'b0, ev.vtime};
         start_seq[d] = ev.seq;
         return;
      end
      if (win_count[d] >= NFRM) win_count[d] = NFRM - 1;
      win_time[d][win_count[d]] = {1'b0, ev.vtime};
      win_seq[d][win_count[d]] = ev.seq;
      win_count[d]++;
      if (win_count[d] >= window_len(d)) close_window(d);
   endtask

   task automatic csr_write(logic [CSR_W-1:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_REFRESH_A, CSR_REFRESH_B, CSR_REFRESH_C, CSR_REFRESH_D: begin
            refresh[idx] = val;
         end
         CSR_ACTIVE_MASK: begin
            active = val[3:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_refresh(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
      csr_write(CSR_REFRESH_A, a);
      csr_write(CSR_REFRESH_B, b);
      csr_write(CSR_REFRESH_C, c);
      csr_write(CSR_REFRESH_D, d);
   endtask

   task automatic push_vblank(int d, logic [63:0] seq, logic [62:0] t);
      vblank_ev_type ev;
      ev.display = DISP_W'(d);
      ev.seq = seq;
      ev.vtime = t;
      pending_events.push_back(ev);
   endtask

   // mostly steady vblank streams with random jitter, some late and backwards, some noise
   task automatic push_random(int count);
      int d, r;
      for (int k = 0; k < count; k++) begin
         d = $urandom_range(0, NDISP - 1);
         r = $urandom_range(0, 99);
         if (r < 82) begin
            r = $urandom_range(0, 99);
            if (r < 75) trk_seq[d] += 1;
            else if (r < 88) trk_seq[d] += 64'($urandom_range(2, 6));
            else if (r < 93) trk_seq[d] += {$urandom, $urandom};
            else trk_seq[d] -= 64'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 90) trk_time[d] += 63'(FRAME_NS + $urandom_range(0, 4000) - 2000);
            else if (r < 95) trk_time[d] -= 63'($urandom_range(0, 100000));
            else trk_time[d] += 63'({$urandom, $urandom} >> $urandom_range(1, 40));
         end else begin
            trk_seq[d] = {$urandom, $urandom};
            trk_time[d] = 63'({$urandom, $urandom});
         end
         push_vblank(d, trk_seq[d], trk_time[d]);
      end
   endtask

   task automatic drain();
      while (pending_events.size() != 0 || req_valid || expected_stats.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_display = 0;
      req_vblank_seq = 0;
      req_vblank_time = 0;
      rsp_stall = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_wdata = 0;
      for (int d = 0; d < NDISP; d++) begin
         refresh[d] = REFRESH_RESET;
         win_count[d] = 0;
         start_time[d] = 0;
         start_seq[d] = 0;
         started[d] = 0;
         trk_seq[d] = 64'($urandom);
         trk_time[d] = 63'($urandom);
      end
      active = ACTIVE_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes of time and sequence, wrap, backwards, inactive display
      set_refresh(8'd1, 8'd2, 8'd3, 8'd1);
      csr_write(CSR_ACTIVE_MASK, 8'h07);
      csr_write(CSR_UNUSED, 8'hff);
      push_vblank(0, 64'd5, 63'd0);
      push_vblank(0, 64'd6, TIME_MAX);
      push_vblank(0, 64'd0, 63'd0);
      push_vblank(0, 64'h0000_0002_0000_0000, 63'd100);
      push_vblank(0, 64'hffff_ffff_ffff_ffff, 63'd5);
      push_vblank(0, 64'd1, 63'd7);
      push_vblank(0, 64'h8000_0000_0000_0001, 63'd9);
      push_vblank(3, 64'd10, 63'd10);
      push_vblank(1, 64'd0, TIME_MAX);
      push_vblank(1, 64'd1, 63'd0);
      push_vblank(1, 64'd9, TIME_MAX);
      push_vblank(2, 64'd100, 63'd1000);
      push_vblank(2, 64'd101, 63'd2000);
      push_vblank(2, 64'd103, 63'd1500);
      push_vblank(2, 64'd104, 63'd100000);
      push_vblank(3, 64'd11, 63'd20);
      drain();
      csr_write(CSR_ACTIVE_MASK, 8'h0f);
      push_vblank(3, 64'd0, 63'd0);
      push_vblank(3, 64'd7, TIME_MAX);
      push_vblank(3, 64'd6, 63'd1);
      drain();

      // small windows with a long receiver hold-off
      set_refresh($urandom_range(1, 8), $urandom_range(1, 8),
                  $urandom_range(1, 8), $urandom_range(1, 8));
      hold_req = 1;
      push_random(450);
      drain();

      // largest windows and an oversize count; the zero count is on an inactive display
      set_refresh(8'd128, 8'd0, 8'd255, 8'd60);
      csr_write(CSR_ACTIVE_MASK, 8'h05);
      push_random(300);
      drain();

      // lower the counts in the middle of a window
      csr_write(CSR_ACTIVE_MASK, 8'h0f);
      set_refresh(8'd40, 8'd40, 8'd40, 8'd40);
      push_random(100);
      drain();
      set_refresh(8'd2, 8'd3, 8'd1, 8'd4);
      push_random(60);
      drain();

      // all displays off, then random settings
      csr_write(CSR_ACTIVE_MASK, 8'h00);
      push_random(20);
      drain();
      csr_write(CSR_ACTIVE_MASK, $urandom_range(1, 15));
      set_refresh($urandom_range(1, 16), $urandom_range(1, 16),
                  $urandom_range(1, 16), $urandom_range(1, 16));
      push_random(450);
      drain();

      // final stretch without idling
      csr_write(CSR_ACTIVE_MASK, 8'h0f);
      set_refresh(8'd1, 8'd3, 8'd5, 8'd2);
      quiet = 1;
      push_random(400);
      drain();

      if (errors == 0)
         $display("vblank_interval_stats: match");
      else
         $display("vblank_interval_stats: mismatch");
      $finish;
   end

   // sender
   always @(negedge clock) begin
      vblank_ev_type ev;
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 12);
            req_valid <= 0;
         end else if (pending_events.size() != 0) begin
            ev = pending_events.pop_front();
            req_display <= ev.display;
            req_vblank_seq <= ev.seq;
            req_vblank_time <= ev.vtime;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_req && !hold_done) begin
            hold_done = 1;
            stall_cnt = 800;
         end
         if (stall_cnt > 0) begin
            stall_cnt--;
            rsp_stall <= 1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_cnt = $urandom_range(0, 12);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      vblank_ev_type ev;
      window_stats_type s;
      cycles++;
      if (cycles > LIMIT) begin
         $display("vblank_interval_stats: mismatch");
         $finish;
      end else begin
         req_taken = req_valid && !req_stall;
         if (!reset && req_taken) begin
            ev.display = req_display;
            ev.seq = req_vblank_seq;
            ev.vtime = req_vblank_time;
            track_vblank(ev);
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               $error("report with none expected, display %0d", rsp_report_display);
               errors++;
            end else begin
               s = expected_stats.pop_front();
               if (rsp_report_display !== s.display) begin
                  $error("report_display exp %0d got %0d", s.display, rsp_report_display);
                  errors++;
               end
               if (rsp_frames !== s.frames) begin
                  $error("frames exp %0d got %0d", s.frames, rsp_frames);
                  errors++;
               end
               if (rsp_total_time !== s.total) begin
                  $error("total_time exp %0d got %0d", s.total, rsp_total_time);
                  errors++;
               end
               if (rsp_mean_interval !== s.mean) begin
                  $error("mean_interval exp %0d got %0d", s.mean, rsp_mean_interval);
                  errors++;
               end
               if (rsp_low_dev !== s.low_dev) begin
                  $error("low_dev exp %0d got %0d", s.low_dev, rsp_low_dev);
                  errors++;
               end
               if (rsp_high_dev !== s.high_dev) begin
                  $error("high_dev exp %0d got %0d", s.high_dev, rsp_high_dev);
                  errors++;
               end
               if (rsp_backwards_count !== s.backwards) begin
                  $error("backwards_count exp %0d got %0d", s.backwards, rsp_backwards_count);
                  errors++;
               end
               if (rsp_late_count !== s.late) begin
                  $error("late_count exp %0d got %0d", s.late, rsp_late_count);
                  errors++;
               end
               if (rsp_min_late_gap !== s.min_gap) begin
                  $error("min_late_gap exp %0d got %0d", s.min_gap, rsp_min_late_gap);
                  errors++;
               end
               if (rsp_max_late_gap !== s.max_gap) begin
                  $error("max_late_gap exp %0d got %0d", s.max_gap, rsp_max_late_gap);
                  errors++;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

/* vblank_interval_stats.f */
rtl/vbis_pkg.sv
rtl/vbis_front.sv
rtl/vbis_queue.sv
rtl/vbis_back.sv
rtl/vblank_interval_stats.sv
rtl/vbis_checker.sv
tb/tb_vblank_interval_stats.sv
